// ----- rtl/rau_pkg.sv -----
// Package with shared constants, types and operand helpers for the rational arithmetic unit.
package rau_pkg;

  localparam int OperandWidth = 32;
  localparam int FieldWidth   = 32;
  localparam int NumWidth     = 64;
  localparam int DenWidth     = 63;
  localparam int CntWidth     = 7;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DEN_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic                neg;
    logic [OperandWidth-1:0] mag;
  } smag_t;

  function automatic smag_t take_operand(logic [FieldWidth-1:0] raw);
    logic [OperandWidth-1:0] v;
    smag_t r;
    v = raw[OperandWidth-1:0];
    r.neg = v[OperandWidth-1];
    r.mag = r.neg ? (~v + OperandWidth'(1)) : v;
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/rau_cell.sv -----
// One bit cell of the divider quotient chain.
module rau_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic load_bit_i,
  input  logic shift_i,
  input  logic shift_bit_i,
  output logic bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = shift_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

// ----- rtl/rau_div.sv -----
// Bit-serial restoring divider built on a chain of quotient cells.
module rau_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rau_pkg::NumWidth-1:0]  dividend_i,
  input  logic [rau_pkg::NumWidth-1:0]  divisor_i,
  output logic                          done_o,
  output logic [rau_pkg::NumWidth-1:0]  quotient_o
);

  logic [rau_pkg::NumWidth-1:0] rem_q, rem_d, rem_s;
  logic [rau_pkg::NumWidth-1:0] q_bits;
  logic [rau_pkg::NumWidth-1:0] shift_in;
  logic [rau_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                         run_q, run_d, done_q, done_d;
  logic                         ge;

  assign rem_s = {rem_q[rau_pkg::NumWidth-2:0], q_bits[rau_pkg::NumWidth-1]};
  assign ge    = rem_s >= divisor_i;
  assign shift_in = {q_bits[rau_pkg::NumWidth-2:0], ge};

  for (genvar i = 0; i < rau_pkg::NumWidth; i++) begin : g_cell
    rau_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (start_i),
      .load_bit_i (dividend_i[i]),
      .shift_i    (run_q),
      .shift_bit_i(shift_in[i]),
      .bit_o      (q_bits[i])
    );
  end

  always_comb begin
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      cnt_d = rau_pkg::CntWidth'(rau_pkg::NumWidth);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? (rem_s - divisor_i) : rem_s;
      cnt_d = cnt_q - rau_pkg::CntWidth'(1);
      if (cnt_q == rau_pkg::CntWidth'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = q_bits;

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit with GCD reduction.
// An operation runs from the start transfer to the done strobe through the shared
// 32x32 multiplier in states S_MUL0, S_MUL1 and S_MUL2, the signed sum in S_SUM, the
// binary GCD loop including the removal of shared factors of two (S_TWOS, S_GCD), and
// two passes through the bit-serial divider (S_DIVN, S_DIVD). Error cases finish
// without leaving idle and a zero result in S_SUM. Busy stays high until the
// result is shown; the result ports are valid from the cycle in which done_o is
// high until the next result, and the receiver cannot stall them.
module rational_arithmetic_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           cmd_i,
  input  logic [rau_pkg::FieldWidth-1:0]       a_num_i,
  input  logic [rau_pkg::FieldWidth-1:0]       a_den_i,
  input  logic [rau_pkg::FieldWidth-1:0]       b_num_i,
  input  logic [rau_pkg::FieldWidth-1:0]       b_den_i,
  output logic                                 done_o,
  output logic [rau_pkg::NumWidth-1:0]         res_num_o,
  output logic [rau_pkg::DenWidth-1:0]         res_den_o,
  output logic [1:0]                           status_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_TWOS = 9'b000100000,
    S_GCD  = 9'b001000000,
    S_DIVN = 9'b010000000,
    S_DIVD = 9'b100000000
  } state_e;

  localparam int W = rau_pkg::OperandWidth;
  localparam int N = rau_pkg::NumWidth;

  state_e state_q, state_d;
  rau_pkg::smag_t an, ad, bn, bd;
  rau_pkg::smag_t an_q, ad_q, bn_q, bd_q;
  rau_pkg::cmd_e  cmd_q;
  logic [N-1:0] p0_q, p1_q, den_q, num_q, x_q, y_q, nm_q, g_q;
  logic [N-1:0] p0_d, p1_d, den_d, num_d, x_d, y_d, nm_d, g_d;
  logic [5:0]   k_q, k_d;
  logic         nneg_q, nneg_d, dneg_q, dneg_d;
  logic         s0, s1;
  logic [W-1:0] ma, mb;
  logic [2*W-1:0] prod;
  logic [N-1:0] sum_mag;
  logic         sum_neg;
  logic         div_start_q, div_start_d, div_done;
  logic [N-1:0] div_quot, div_dividend;
  logic         done_q, done_d;
  logic [N-1:0] res_num_q, res_num_d;
  logic [rau_pkg::DenWidth-1:0] res_den_q, res_den_d;
  logic [1:0]   status_q, status_d;
  logic [N-1:0] xy_diff, yx_diff;

  assign an = rau_pkg::take_operand(a_num_i);
  assign ad = rau_pkg::take_operand(a_den_i);
  assign bn = rau_pkg::take_operand(b_num_i);
  assign bd = rau_pkg::take_operand(b_den_i);

  always_comb begin
    ma = an_q.mag;
    mb = bd_q.mag;
    unique case (state_q)
      S_MUL0: begin
        ma = an_q.mag;
        mb = (cmd_q == rau_pkg::CMD_MUL) ? bn_q.mag : bd_q.mag;
      end
      S_MUL1: begin
        ma = bn_q.mag;
        mb = ad_q.mag;
      end
      S_MUL2: begin
        ma = ad_q.mag;
        mb = (cmd_q == rau_pkg::CMD_DIV) ? bn_q.mag : bd_q.mag;
      end
      default: begin
        ma = an_q.mag;
        mb = bd_q.mag;
      end
    endcase
  end

  assign prod = ma * mb;
  assign s0 = an_q.neg ^ ((cmd_q == rau_pkg::CMD_MUL) ? bn_q.neg : bd_q.neg);
  assign s1 = bn_q.neg ^ ad_q.neg ^ (cmd_q == rau_pkg::CMD_SUB);

  always_comb begin
    if (s0 == s1) begin
      sum_mag = p0_q + p1_q;
      sum_neg = s0;
    end else if (p0_q >= p1_q) begin
      sum_mag = p0_q - p1_q;
      sum_neg = s0;
    end else begin
      sum_mag = p1_q - p0_q;
      sum_neg = s1;
    end
  end

  assign xy_diff = x_q - y_q;
  assign yx_diff = y_q - x_q;
  assign div_dividend = (state_q == S_DIVN) ? num_q : den_q;

  rau_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dividend),
    .divisor_i (g_q),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  always_comb begin
    state_d     = state_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    den_d       = den_q;
    num_d       = num_q;
    x_d         = x_q;
    y_d         = y_q;
    nm_d        = nm_q;
    g_d         = g_q;
    k_d         = k_q;
    nneg_d      = nneg_q;
    dneg_d      = dneg_q;
    div_start_d = 1'b0;
    done_d      = 1'b0;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    status_d    = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (ad.mag == '0 || bd.mag == '0) begin
            done_d    = 1'b1;
            res_num_d = '0;
            res_den_d = '0;
            status_d  = rau_pkg::ST_DEN_ZERO;
          end else if (rau_pkg::cmd_e'(cmd_i) == rau_pkg::CMD_DIV && bn.mag == '0) begin
            done_d    = 1'b1;
            res_num_d = '0;
            res_den_d = '0;
            status_d  = rau_pkg::ST_DIV_ZERO;
          end else begin
            state_d = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        p0_d    = N'(prod);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        p1_d    = N'(prod);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        den_d   = N'(prod);
        dneg_d  = ad_q.neg ^ ((cmd_q == rau_pkg::CMD_DIV) ? bn_q.neg : bd_q.neg);
        state_d = S_SUM;
      end
      S_SUM: begin
        if (cmd_q == rau_pkg::CMD_ADD || cmd_q == rau_pkg::CMD_SUB) begin
          num_d  = sum_mag;
          nneg_d = sum_neg;
        end else begin
          num_d  = p0_q;
          nneg_d = s0;
        end
        x_d = num_d;
        y_d = den_q;
        k_d = '0;
        if (num_d == '0) begin
          done_d    = 1'b1;
          res_num_d = '0;
          res_den_d = rau_pkg::DenWidth'(1);
          status_d  = rau_pkg::ST_OK;
          state_d   = S_IDLE;
        end else begin
          state_d = S_TWOS;
        end
      end
      S_TWOS: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 6'd1;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (x_q == '0) begin
          g_d         = y_q << k_q;
          div_start_d = 1'b1;
          state_d     = S_DIVN;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = xy_diff >> 1;
        end else begin
          y_d = yx_diff >> 1;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          nm_d        = div_quot;
          div_start_d = 1'b1;
          state_d     = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          done_d    = 1'b1;
          res_num_d = (nneg_q ^ dneg_q) ? (N'(0) - nm_q) : nm_q;
          res_den_d = div_quot[rau_pkg::DenWidth-1:0];
          status_d  = rau_pkg::ST_OK;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      an_q  <= an;
      ad_q  <= ad;
      bn_q  <= bn;
      bd_q  <= bd;
      cmd_q <= rau_pkg::cmd_e'(cmd_i);
    end
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    den_q     <= den_d;
    num_q     <= num_d;
    x_q       <= x_d;
    y_q       <= y_d;
    nm_q      <= nm_d;
    g_q       <= g_d;
    k_q       <= k_d;
    nneg_q    <= nneg_d;
    dneg_q    <= dneg_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    status_q  <= status_d;
  end

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule
